>>> rtl/mfvn_pkg.sv
// Shared types, codes and constants of the mesh normals unit.
package mfvn_pkg;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_BITS_DEF   = 16;
   localparam int IDX_IN_W         = 10;
   localparam int COORD_IN_W       = 16;
   localparam int NORM_W           = 16;
   localparam int SUM_W            = 32;
   localparam int MUL_W            = 33;
   localparam int Q_SHIFT          = 14;
   localparam int ROOT_STEPS       = 32;
   localparam int DIV_BITS         = 45;
   localparam int MAG_W            = 31;
   localparam int CNT_W            = 6;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_TRI  = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [4:0] {
      DP_NOP        = 5'd0,
      DP_LATCH      = 5'd1,
      DP_REDUCE     = 5'd2,
      DP_LOAD       = 5'd3,
      DP_PT_CAP     = 5'd4,
      DP_DIFF       = 5'd5,
      DP_X_MUL      = 5'd6,
      DP_X_ACC      = 5'd7,
      DP_SUM_CAP    = 5'd8,
      DP_ABS        = 5'd9,
      DP_SHIFT      = 5'd10,
      DP_SQ_MUL     = 5'd11,
      DP_SQ_ACC     = 5'd12,
      DP_ROOT_INIT  = 5'd13,
      DP_ROOT_STEP  = 5'd14,
      DP_DIV_INIT   = 5'd15,
      DP_DIV_STEP   = 5'd16,
      DP_DIV_STORE  = 5'd17,
      DP_ZERO       = 5'd18,
      DP_ACC_WR     = 5'd19
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] step;
      logic       face;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_ok;
      logic too_big;
      logic len_zero;
   } dp_status_type;

endpackage

>>> rtl/mfvn_datapath.sv
// Datapath: vertex and sum memories, shared multiplier, square root and divider.
module mfvn_datapath #(
   parameter int MAX_VERTICES = mfvn_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = mfvn_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  mfvn_pkg::dp_cmd_type                   cmd,
   output mfvn_pkg::dp_status_type                status,
   input  logic                                   negate,
   input  logic [1:0]                             req_opcode,
   input  logic [mfvn_pkg::IDX_IN_W-1:0]          req_index_a,
   input  logic [mfvn_pkg::IDX_IN_W-1:0]          req_index_b,
   input  logic [mfvn_pkg::IDX_IN_W-1:0]          req_index_c,
   input  logic signed [mfvn_pkg::COORD_IN_W-1:0] req_coord_x,
   input  logic signed [mfvn_pkg::COORD_IN_W-1:0] req_coord_y,
   input  logic signed [mfvn_pkg::COORD_IN_W-1:0] req_coord_z,
   output logic                                   rsp_kind,
   output logic signed [mfvn_pkg::NORM_W-1:0]     rsp_norm_x,
   output logic signed [mfvn_pkg::NORM_W-1:0]     rsp_norm_y,
   output logic signed [mfvn_pkg::NORM_W-1:0]     rsp_norm_z,
   output logic                                   rsp_degenerate
);

   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int XW  = (AW > mfvn_pkg::IDX_IN_W) ? AW : mfvn_pkg::IDX_IN_W;
   localparam int RS  = XW - AW + 1;
   localparam int C   = COORD_BITS;
   localparam int EW  = C + mfvn_pkg::COORD_IN_W;
   localparam int DW  = C + 1;
   localparam int VW  = (2 * C + 2 > mfvn_pkg::SUM_W) ? 2 * C + 2 : mfvn_pkg::SUM_W;
   localparam int PW  = 2 * mfvn_pkg::MUL_W;
   localparam int SW  = mfvn_pkg::SUM_W;
   localparam int NW  = mfvn_pkg::NORM_W;
   localparam int MW  = mfvn_pkg::MAG_W;
   localparam int QW  = mfvn_pkg::Q_SHIFT;
   localparam int DVW = mfvn_pkg::DIV_BITS;

   logic [XW-1:0]          idx_ff [3];
   logic [C-1:0]           coord_ff [3];
   logic signed [C-1:0]    p_ff [3][3];
   logic signed [DW-1:0]   d1_ff [3];
   logic signed [DW-1:0]   d2_ff [3];
   logic signed [PW-1:0]   prod_ff;
   logic signed [VW-1:0]   v_ff [3];
   logic [VW-1:0]          m_ff [3];
   logic                   sgn_ff [3];
   logic [63:0]            sq_ff;
   logic [63:0]            rem_ff;
   logic [63:0]            res_ff;
   logic [63:0]            bit_ff;
   logic [DVW-1:0]         dvd_ff;
   logic [32:0]            r_ff;
   logic [NW-1:0]          q_ff;
   logic signed [NW-1:0]   n_ff [3];
   logic                   kind_ff;
   logic                   deg_ff;
   logic [3*C-1:0]         pt_rdata_ff;
   logic [3*SW-1:0]        sum_rdata_ff;

   logic [3*C-1:0]         pt_mem  [MAX_VERTICES];
   logic [3*SW-1:0]        sum_mem [MAX_VERTICES];

   logic [1:0]             corner;
   logic [AW-1:0]          addr;
   logic [1:0]             ia;
   logic [1:0]             ib;
   logic [1:0]             xk;
   logic signed [mfvn_pkg::MUL_W-1:0] mul_a;
   logic signed [mfvn_pkg::MUL_W-1:0] mul_b;
   logic [63:0]            trial;
   logic [32:0]            r_sh;
   logic [EW-1:0]          ext [3];
   logic [3*SW-1:0]        sum_wdata;
   logic                   flip;
   logic [XW-1:0]          red [3];

   function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                    input logic signed [NW-1:0] b);
      logic signed [SW:0] s;
      s = (SW+1)'(a) + (SW+1)'(b);
      if (s[SW] != s[SW-1]) begin
         sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sat_add = s[SW-1:0];
      end
   endfunction

   assign corner = cmd.step[1:0];
   assign xk     = 2'(cmd.step >> 1);

   always_comb begin
      unique case (corner)
         2'd1:    addr = idx_ff[1][AW-1:0];
         2'd2:    addr = idx_ff[2][AW-1:0];
         default: addr = idx_ff[0][AW-1:0];
      endcase
   end

   // Each reduction cycle removes the largest shifted multiple of the depth that fits.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         red[k] = idx_ff[k];
         for (int s = 0; s < RS; s++) begin
            if ({1'b0, idx_ff[k]} >= ((XW+1)'(MAX_VERTICES) << s)) begin
               red[k] = XW'({1'b0, idx_ff[k]} - ((XW+1)'(MAX_VERTICES) << s));
            end
         end
      end
   end

   // Operand pairs of the six cross product terms, two per component.
   always_comb begin
      unique case (cmd.step)
         3'd0:    begin ia = 2'd1; ib = 2'd2; end
         3'd1:    begin ia = 2'd2; ib = 2'd1; end
         3'd2:    begin ia = 2'd2; ib = 2'd0; end
         3'd3:    begin ia = 2'd0; ib = 2'd2; end
         3'd4:    begin ia = 2'd0; ib = 2'd1; end
         default: begin ia = 2'd1; ib = 2'd0; end
      endcase
   end

   always_comb begin
      if (cmd.op == mfvn_pkg::DP_SQ_MUL) begin
         mul_a = $signed(mfvn_pkg::MUL_W'(m_ff[corner][MW-1:0]));
         mul_b = mul_a;
      end else begin
         mul_a = mfvn_pkg::MUL_W'(d1_ff[ia]);
         mul_b = mfvn_pkg::MUL_W'(d2_ff[ib]);
      end
   end

   assign trial = res_ff + bit_ff;
   assign r_sh  = {r_ff[31:0], dvd_ff[DVW-1]};
   assign flip  = sgn_ff[corner] ^ (cmd.face & negate);

   assign ext[0] = EW'($unsigned(req_coord_x));
   assign ext[1] = EW'($unsigned(req_coord_y));
   assign ext[2] = EW'($unsigned(req_coord_z));

   always_comb begin
      if (cmd.op == mfvn_pkg::DP_LOAD) begin
         sum_wdata = '0;
      end else begin
         sum_wdata = {sat_add($signed(sum_rdata_ff[2*SW +: SW]), n_ff[2]),
                      sat_add($signed(sum_rdata_ff[SW +: SW]), n_ff[1]),
                      sat_add($signed(sum_rdata_ff[0 +: SW]), n_ff[0])};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mfvn_pkg::DP_LOAD) begin
         pt_mem[addr] <= {coord_ff[2], coord_ff[1], coord_ff[0]};
      end
      pt_rdata_ff <= pt_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mfvn_pkg::DP_LOAD || cmd.op == mfvn_pkg::DP_ACC_WR) begin
         sum_mem[addr] <= sum_wdata;
      end
      sum_rdata_ff <= sum_mem[addr];
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         mfvn_pkg::DP_LATCH: begin
            idx_ff[0] <= XW'(req_index_a);
            idx_ff[1] <= XW'(req_index_b);
            idx_ff[2] <= XW'(req_index_c);
            for (int k = 0; k < 3; k++) begin
               coord_ff[k] <= ext[k][C-1:0];
            end
            kind_ff <= (req_opcode == mfvn_pkg::OP_READ);
         end
         mfvn_pkg::DP_REDUCE: begin
            for (int k = 0; k < 3; k++) begin
               idx_ff[k] <= red[k];
            end
         end
         mfvn_pkg::DP_PT_CAP: begin
            for (int k = 0; k < 3; k++) begin
               p_ff[corner][k] <= $signed(pt_rdata_ff[k*C +: C]);
            end
         end
         mfvn_pkg::DP_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               d1_ff[k] <= DW'(p_ff[2][k]) - DW'(p_ff[1][k]);
               d2_ff[k] <= DW'(p_ff[1][k]) - DW'(p_ff[0][k]);
            end
         end
         mfvn_pkg::DP_X_MUL, mfvn_pkg::DP_SQ_MUL: begin
            prod_ff <= mul_a * mul_b;
         end
         mfvn_pkg::DP_X_ACC: begin
            if (!cmd.step[0]) begin
               v_ff[xk] <= VW'(prod_ff);
            end else begin
               v_ff[xk] <= v_ff[xk] - VW'(prod_ff);
            end
         end
         mfvn_pkg::DP_SUM_CAP: begin
            for (int k = 0; k < 3; k++) begin
               v_ff[k] <= VW'($signed(sum_rdata_ff[k*SW +: SW]));
            end
         end
         mfvn_pkg::DP_ABS: begin
            for (int k = 0; k < 3; k++) begin
               m_ff[k]   <= v_ff[k][VW-1] ? VW'(-v_ff[k]) : VW'(v_ff[k]);
               sgn_ff[k] <= v_ff[k][VW-1];
            end
         end
         mfvn_pkg::DP_SHIFT: begin
            for (int k = 0; k < 3; k++) begin
               m_ff[k] <= m_ff[k] >> 1;
            end
         end
         mfvn_pkg::DP_SQ_ACC: begin
            sq_ff <= ((corner == 2'd0) ? 64'd0 : sq_ff) + 64'(prod_ff);
         end
         mfvn_pkg::DP_ROOT_INIT: begin
            rem_ff <= sq_ff;
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end
         mfvn_pkg::DP_ROOT_STEP: begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         mfvn_pkg::DP_DIV_INIT: begin
            dvd_ff <= {m_ff[corner][MW-1:0], {QW{1'b0}}};
            r_ff   <= '0;
            q_ff   <= '0;
            deg_ff <= 1'b0;
         end
         mfvn_pkg::DP_DIV_STEP: begin
            if (r_sh >= {1'b0, res_ff[31:0]}) begin
               r_ff <= r_sh - {1'b0, res_ff[31:0]};
               q_ff <= {q_ff[NW-2:0], 1'b1};
            end else begin
               r_ff <= r_sh;
               q_ff <= {q_ff[NW-2:0], 1'b0};
            end
            dvd_ff <= dvd_ff << 1;
         end
         mfvn_pkg::DP_DIV_STORE: begin
            n_ff[corner] <= flip ? -$signed(q_ff) : $signed(q_ff);
         end
         mfvn_pkg::DP_ZERO: begin
            for (int k = 0; k < 3; k++) begin
               n_ff[k] <= '0;
            end
            deg_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.idx_ok = 1'b1;
      status.too_big = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if ({1'b0, idx_ff[k]} >= (XW+1)'(MAX_VERTICES)) begin
            status.idx_ok = 1'b0;
         end
         if (|m_ff[k][VW-1:MW]) begin
            status.too_big = 1'b1;
         end
      end
      status.len_zero = (res_ff == 64'd0);
   end

   assign rsp_kind       = kind_ff;
   assign rsp_norm_x     = n_ff[0];
   assign rsp_norm_y     = n_ff[1];
   assign rsp_norm_z     = n_ff[2];
   assign rsp_degenerate = deg_ff;

endmodule

>>> rtl/mfvn_controller.sv
// Controller: sequences the datapath through load, face and vertex normal work.
module mfvn_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_opcode,
   output logic                    busy,
   output logic                    rsp_strobe,
   output mfvn_pkg::dp_cmd_type    cmd,
   input  mfvn_pkg::dp_status_type status
);

   typedef enum logic [21:0] {
      ST_IDLE      = 22'h000001,
      ST_REDUCE    = 22'h000002,
      ST_LOAD      = 22'h000004,
      ST_PT_RD     = 22'h000008,
      ST_PT_CAP    = 22'h000010,
      ST_DIFF      = 22'h000020,
      ST_X_MUL     = 22'h000040,
      ST_X_ACC     = 22'h000080,
      ST_SUM_RD    = 22'h000100,
      ST_SUM_CAP   = 22'h000200,
      ST_ABS       = 22'h000400,
      ST_SHIFT     = 22'h000800,
      ST_SQ_MUL    = 22'h001000,
      ST_SQ_ACC    = 22'h002000,
      ST_ROOT_INIT = 22'h004000,
      ST_ROOT      = 22'h008000,
      ST_DIV_INIT  = 22'h010000,
      ST_DIV       = 22'h020000,
      ST_DIV_STORE = 22'h040000,
      ST_ACC_RD    = 22'h080000,
      ST_ACC_WR    = 22'h100000,
      ST_EMIT      = 22'h200000
   } state_type;

   state_type                     state_ff, state_in;
   logic [2:0]                    step_ff, step_in;
   logic [mfvn_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [1:0]                    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      cmd.op   = mfvn_pkg::DP_NOP;
      cmd.step = step_ff;
      cmd.face = (op_ff == mfvn_pkg::OP_TRI);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = mfvn_pkg::DP_LATCH;
               op_in    = req_opcode;
               step_in  = '0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.op = mfvn_pkg::DP_REDUCE;
            if (status.idx_ok) begin
               unique case (op_ff)
                  mfvn_pkg::OP_LOAD: state_in = ST_LOAD;
                  mfvn_pkg::OP_TRI:  state_in = ST_PT_RD;
                  mfvn_pkg::OP_READ: state_in = ST_SUM_RD;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.op   = mfvn_pkg::DP_LOAD;
            state_in = ST_IDLE;
         end
         ST_PT_RD: begin
            state_in = ST_PT_CAP;
         end
         ST_PT_CAP: begin
            cmd.op = mfvn_pkg::DP_PT_CAP;
            if (step_ff == 3'd2) begin
               state_in = ST_DIFF;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_PT_RD;
            end
         end
         ST_DIFF: begin
            cmd.op   = mfvn_pkg::DP_DIFF;
            step_in  = '0;
            state_in = ST_X_MUL;
         end
         ST_X_MUL: begin
            cmd.op   = mfvn_pkg::DP_X_MUL;
            state_in = ST_X_ACC;
         end
         ST_X_ACC: begin
            cmd.op = mfvn_pkg::DP_X_ACC;
            if (step_ff == 3'd5) begin
               state_in = ST_ABS;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_X_MUL;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_CAP;
         end
         ST_SUM_CAP: begin
            cmd.op   = mfvn_pkg::DP_SUM_CAP;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd.op   = mfvn_pkg::DP_ABS;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (status.too_big) begin
               cmd.op = mfvn_pkg::DP_SHIFT;
            end else begin
               step_in  = '0;
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            cmd.op   = mfvn_pkg::DP_SQ_MUL;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            cmd.op = mfvn_pkg::DP_SQ_ACC;
            if (step_ff == 3'd2) begin
               state_in = ST_ROOT_INIT;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_ROOT_INIT: begin
            cmd.op   = mfvn_pkg::DP_ROOT_INIT;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op = mfvn_pkg::DP_ROOT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mfvn_pkg::CNT_W'(mfvn_pkg::ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cnt_in = '0;
            if (status.len_zero) begin
               cmd.op   = mfvn_pkg::DP_ZERO;
               step_in  = '0;
               state_in = cmd.face ? ST_ACC_RD : ST_EMIT;
            end else begin
               cmd.op   = mfvn_pkg::DP_DIV_INIT;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = mfvn_pkg::DP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mfvn_pkg::CNT_W'(mfvn_pkg::DIV_BITS - 1)) begin
               state_in = ST_DIV_STORE;
            end
         end
         ST_DIV_STORE: begin
            cmd.op = mfvn_pkg::DP_DIV_STORE;
            if (step_ff == 3'd2) begin
               step_in  = '0;
               state_in = cmd.face ? ST_ACC_RD : ST_EMIT;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_ACC_RD: begin
            state_in = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            cmd.op = mfvn_pkg::DP_ACC_WR;
            if (step_ff == 3'd2) begin
               state_in = ST_EMIT;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_ACC_RD;
            end
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_EMIT);

endmodule

>>> rtl/mesh_face_and_vertex_normals_unit.sv
// Top level of the mesh face and vertex normals unit.
//
//   channel  | handshake           | carries
//   ---------+---------------------+--------------------------------------------
//   req      | start / busy        | opcode, three vertex indexes, coordinates
//   rsp      | rsp_strobe          | kind, Q1.14 normal, degenerate flag
//   csr      | csr_valid/csr_ready | negate_normal
//
// One item is handled at a time: a new one is accepted only once the unit is idle.
// A triangle or a vertex normal read runs the 32-step square root and three
// 45-step restoring divisions on one shared divider; a zero-length vector skips
// the divisions. Large vectors are first shifted right until they fit.
// Indexes at or above MAX_VERTICES are reduced modulo MAX_VERTICES before use.
// Reset is synchronous; negate_normal resets to 1. The memories are not
// cleared. Results cannot be stalled: each is shown for one cycle.
module mesh_face_and_vertex_normals_unit #(
   parameter int MAX_VERTICES = mfvn_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = mfvn_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_opcode,
   input  logic [mfvn_pkg::IDX_IN_W-1:0]          req_index_a,
   input  logic [mfvn_pkg::IDX_IN_W-1:0]          req_index_b,
   input  logic [mfvn_pkg::IDX_IN_W-1:0]          req_index_c,
   input  logic signed [mfvn_pkg::COORD_IN_W-1:0] req_coord_x,
   input  logic signed [mfvn_pkg::COORD_IN_W-1:0] req_coord_y,
   input  logic signed [mfvn_pkg::COORD_IN_W-1:0] req_coord_z,
   output logic                                   rsp_strobe,
   output logic                                   rsp_kind,
   output logic signed [mfvn_pkg::NORM_W-1:0]     rsp_norm_x,
   output logic signed [mfvn_pkg::NORM_W-1:0]     rsp_norm_y,
   output logic signed [mfvn_pkg::NORM_W-1:0]     rsp_norm_z,
   output logic                                   rsp_degenerate,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic                                   csr_negate_normal
);

   mfvn_pkg::dp_cmd_type    cmd;
   mfvn_pkg::dp_status_type status;
   logic                    negate_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         negate_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         negate_ff <= csr_negate_normal;
      end
   end

   mfvn_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   mfvn_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .negate         (negate_ff),
      .req_opcode     (req_opcode),
      .req_index_a    (req_index_a),
      .req_index_b    (req_index_b),
      .req_index_c    (req_index_c),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .rsp_kind       (rsp_kind),
      .rsp_norm_x     (rsp_norm_x),
      .rsp_norm_y     (rsp_norm_y),
      .rsp_norm_z     (rsp_norm_z),
      .rsp_degenerate (rsp_degenerate)
   );

   // A result is only ever shown while an item is in hand.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside an item");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the unit busy");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("more than one result for one item");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_norm_x <= 16'sd16384 && rsp_norm_x >= -16'sd16384 &&
                     rsp_norm_y <= 16'sd16384 && rsp_norm_y >= -16'sd16384 &&
                     rsp_norm_z <= 16'sd16384 && rsp_norm_z >= -16'sd16384)
      else $error("normal component beyond unit length");

endmodule
